// File: hw/rtl/bds_pkg.sv
// Shared constants and register codes for the 2x2 box downsampler.
// No dependencies; imported by the interfaces and box_downsample_2x2.
package bds_pkg;

  localparam int PIX_W      = 8;   // input and output pixel width
  localparam int SUM_W      = 9;   // horizontal pair sum width
  localparam int CFG_WID_W  = 11;  // image_width register width
  localparam int CFG_HGT_W  = 13;  // image_height register width
  localparam int CFG_DATA_W = 13;  // widest register
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [CFG_WID_W-1:0] WIDTH_RESET  = 11'd4;
  localparam logic [CFG_HGT_W-1:0] HEIGHT_RESET = 13'd4;

endpackage

// File: hw/rtl/bds_stream_if.sv
// Valid/ready stream interfaces for input pixels and downsampled results.
// Depends on bds_pkg.
interface bds_pixel_if;
  import bds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bds_result_if;
  import bds_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] avg_pixel;
  logic             frame_last;
  logic             odd_size_error;

  modport source (output valid, output avg_pixel, output frame_last,
                  output odd_size_error, input ready);
  modport sink (input valid, input avg_pixel, input frame_last,
                input odd_size_error, output ready);
endinterface

// File: hw/rtl/bds_line_ram.sv
// Single line store of pair sums: one write port, one read port, registered read.
// No dependencies.
module bds_line_ram #(
  parameter int DEPTH = 512,
  parameter int AW    = 9,
  parameter int DW    = 9
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: hw/rtl/box_downsample_2x2.sv
// 2x2 box-average downsampler: raster pixels in, half-size raster averages out, or one zero error result for odd sizes.
// Depends on bds_pkg, bds_stream_if and bds_line_ram.
// A result is registered in stage 1 and then in the output register after its pixel transfer.
// Throughput: 1 pixel per cycle unless the output stalls; at most one line-store write or read per pixel.
// Reset (synchronous, rst high): counters cleared, width and height back to 4,
// pipeline emptied. The line store is not cleared; each entry is written on an
// even row before the following odd row reads it.
module box_downsample_2x2 #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  bds_pixel_if.sink                     pixels,
  bds_result_if.source                  results,
  input  logic                          cfg_we,
  input  logic [bds_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bds_pkg::CFG_DATA_W-1:0] cfg_data
);
  import bds_pkg::*;

  localparam int LINE_DEPTH = MAX_WIDTH / 2;
  localparam int AW         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW         = $clog2(MAX_WIDTH);
  localparam int RW         = $clog2(MAX_HEIGHT);
  localparam int WE_W       = $clog2(MAX_WIDTH + 1);
  localparam int HE_W       = $clog2(MAX_HEIGHT + 1);

  logic [CFG_WID_W-1:0] image_width;
  logic [CFG_HGT_W-1:0] image_height;
  logic [CW-1:0]        col;
  logic [RW-1:0]        row;
  logic [PIX_W-1:0]     left_pixel;

  logic [WE_W-1:0] w_eff;
  logic [HE_W-1:0] h_eff;
  logic            err_mode;
  logic            last_col;
  logic            last_row;
  logic            accept;
  logic            produce;
  logic [SUM_W-1:0] pair;
  logic [AW-1:0]   idx;
  logic            ram_we;
  logic            ram_re;
  logic [SUM_W-1:0] ram_rdata;

  logic             s1_valid;
  logic [SUM_W-1:0] s1_pair;
  logic             s1_last;
  logic             s1_err;
  logic             s1_advance;
  logic [SUM_W:0]   block_sum;

  // dimension clamp: zero reads as one, oversize reads as the maximum
  always_comb begin
    if (image_width == '0) begin
      w_eff = WE_W'(1);
    end else if (int'(image_width) > MAX_WIDTH) begin
      w_eff = WE_W'(MAX_WIDTH);
    end else begin
      w_eff = WE_W'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HE_W'(1);
    end else if (int'(image_height) > MAX_HEIGHT) begin
      h_eff = HE_W'(MAX_HEIGHT);
    end else begin
      h_eff = HE_W'(image_height);
    end
  end

  assign err_mode = w_eff[0] | h_eff[0];
  assign last_col = (WE_W'(col) + WE_W'(1)) >= w_eff;
  assign last_row = (HE_W'(row) + HE_W'(1)) >= h_eff;

  assign s1_advance   = s1_valid && (!results.valid || results.ready);
  assign pixels.ready = !s1_valid || s1_advance;
  assign accept       = pixels.valid && pixels.ready;

  assign produce = err_mode ? (last_col && last_row) : (col[0] && row[0]);
  assign pair    = SUM_W'(left_pixel) + SUM_W'(pixels.pixel);
  assign idx     = AW'(col >> 1);
  assign ram_we  = accept && !err_mode && col[0] && !row[0];
  assign ram_re  = accept && !err_mode && col[0] && row[0];

  bds_line_ram #(
    .DEPTH (LINE_DEPTH),
    .AW    (AW),
    .DW    (SUM_W)
  ) u_line (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx),
    .wr_data (pair),
    .rd_en   (ram_re),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  // config registers and frame position
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      left_pixel   <= '0;
    end else if (cfg_we && (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT)) begin
      if (cfg_index == REG_IMAGE_WIDTH) begin
        image_width <= cfg_data[CFG_WID_W-1:0];
      end else begin
        image_height <= cfg_data[CFG_HGT_W-1:0];
      end
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (!err_mode && !col[0]) begin
        left_pixel <= pixels.pixel;
      end
      if (last_col) begin
        col <= '0;
        row <= last_row ? '0 : row + RW'(1);
      end else begin
        col <= col + CW'(1);
      end
    end
  end

  // stage 1 waits on the line-store read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= produce;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (accept) begin
      s1_pair <= pair;
      s1_last <= last_col && last_row;
      s1_err  <= err_mode;
    end
  end

  assign block_sum = (SUM_W + 1)'(ram_rdata) + (SUM_W + 1)'(s1_pair);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (s1_advance) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
    if (s1_advance) begin
      results.avg_pixel      <= s1_err ? '0 : block_sum[SUM_W:2];
      results.frame_last     <= s1_last;
      results.odd_size_error <= s1_err;
    end
  end

  a_ram_ports_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("line store written and read in the same cycle");

  a_col_in_range: assert property (@(posedge clk) disable iff (rst)
    WE_W'(col) < w_eff)
    else $error("column count beyond configured width");

  a_s1_held: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_advance |=> s1_valid && $stable(s1_pair))
    else $error("stalled result lost in stage 1");

  a_err_result: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.odd_size_error |-> results.frame_last && results.avg_pixel == '0)
    else $error("error result not marked as frame end");

endmodule
